// File: sv/sse_pkg.sv
package sse_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OP_W      = 4;
    localparam int STATUS_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 4'd0,
        OP_REMOVE   = 4'd1,
        OP_EXISTS   = 4'd2,
        OP_MIN      = 4'd3,
        OP_MAX      = 4'd4,
        OP_POP_MIN  = 4'd5,
        OP_POP_MAX  = 4'd6,
        OP_PRED     = 4'd7,
        OP_POP_PRED = 4'd8,
        OP_SUCC     = 4'd9,
        OP_POP_SUCC = 4'd10,
        OP_CLEAR    = 4'd11
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_NONE  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    // Which cells pull their key from the right-hand neighbor on a removal
    typedef enum logic [1:0] {
        RM_ALL,
        RM_FROM_LT,
        RM_FROM_LE,
        RM_FROM_PRED
    } rm_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic     cmp;
        logic     ins;
        logic     rm;
        rm_mode_t mode;
    } cell_ctl_t;

endpackage

// File: sv/sse_cell.sv
module sse_cell (
    input  logic                           clk,
    input  sse_pkg::cell_ctl_t             ctl,
    input  logic                           occ,
    input  logic [sse_pkg::KEY_WIDTH-1:0]  key_bcast,
    input  logic [sse_pkg::KEY_WIDTH-1:0]  left_key,
    input  logic [sse_pkg::KEY_WIDTH-1:0]  right_key,
    input  logic                           left_lt,
    input  logic                           right_lt,
    output logic [sse_pkg::KEY_WIDTH-1:0]  key_q,
    output logic                           lt_q,
    output logic                           le_q
);
    import sse_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 lt_reg;
    logic                 lt_next;
    logic                 le_reg;
    logic                 le_next;
    logic                 rm_here;

    always_comb
    begin
        case (ctl.mode)
            RM_ALL:       rm_here = 1'b1;
            RM_FROM_LT:   rm_here = !lt_reg;
            RM_FROM_LE:   rm_here = !le_reg;
            RM_FROM_PRED: rm_here = !right_lt;
            default:      rm_here = 1'b0;
        endcase
    end

    always_comb
    begin
        key_next = key_reg;
        lt_next  = lt_reg;
        le_next  = le_reg;
        if (ctl.cmp)
        begin
            lt_next = occ && (key_reg < key_bcast);
            le_next = occ && (key_reg <= key_bcast);
        end
        // insert: the first cell not below the key takes it, the rest move right
        if (ctl.ins && !lt_reg)
        begin
            key_next = left_lt ? key_bcast : left_key;
        end
        // remove: close the gap from the right
        if (ctl.rm && rm_here)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        le_reg  <= le_next;
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;
    assign le_q  = le_reg;

endmodule

// File: sv/sorted_set_engine_unit.sv
// Sorted set engine: holds up to CAPACITY distinct unsigned keys in ascending
// order in a row of cells, cell i holding the i-th smallest key.
// Input channel (in_valid/in_ready): opcode and key of one request.
// Output channel (out_valid/out_ready): status, value and count after the
// request; every request yields exactly one result transaction.
// Each request passes through the cell row after it is accepted: a compare
// step in which every cell compares its key against the broadcast key and
// registers the flags, and an update step in which the cells shift left or right
// together and the result is registered. in_ready returns only in the cycle
// after the update, so the unit takes no new request until the current one
// has updated the cell row.
// A finished result waits in the output register while the next request is
// taken and compared; a stalled receiver holds that request in its update
// cycle until the output register frees up.
// Reset empties the set at once; the key cells themselves are not cleared.
module sorted_set_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [sse_pkg::OP_W-1:0]           opcode,
    input  logic [sse_pkg::KEY_WIDTH-1:0]      key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sse_pkg::STATUS_W-1:0]       status,
    output logic [sse_pkg::KEY_WIDTH-1:0]      value,
    output logic [sse_pkg::CNT_W-1:0]          count
);
    import sse_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    op_t                  op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    logic                 out_valid_reg;
    status_t              status_reg;
    logic [KEY_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]     cnt_out_reg;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic                 cmp_en;

    logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]  lt;
    logic [CAPACITY-1:0]  le;
    logic [CAPACITY-1:0]  occ;
    logic [CAPACITY-1:0]  lt_up;
    logic [CAPACITY-1:0]  occ_up;
    logic [CAPACITY-1:0]  le_dn;
    logic [CAPACITY-1:0]  sel_last;
    logic [CAPACITY-1:0]  sel_pred;
    logic [CAPACITY-1:0]  sel_succ;
    logic [CAPACITY-1:0]  sel;

    logic                 found;
    logic                 succ_exists;
    logic                 empty;
    logic                 full;
    logic [KEY_WIDTH-1:0] sel_key;
    status_t              status_next;
    logic                 use_sel;
    logic                 ins_req;
    logic                 rm_req;
    rm_mode_t             rm_mode;
    cell_ctl_t            ctl;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CMP;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmp_en   = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_CMP:   cmp_en   = 1'b1;
            S_APPLY: commit   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(opcode);
            key_reg <= key;
        end
    end

    // ---------------- cell row ----------------
    assign lt_up  = {1'b0, lt[CAPACITY-1:1]};
    assign occ_up = {1'b0, occ[CAPACITY-1:1]};
    assign le_dn  = {le[CAPACITY-2:0], 1'b1};

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] left_key;
            logic [KEY_WIDTH-1:0] right_key;
            logic                 left_lt;
            logic                 right_lt;

            assign occ[i] = (cnt_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign left_key = key_reg;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_mid_l
                assign left_key = cell_key[i-1];
                assign left_lt  = lt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_key = key_reg;
                assign right_lt  = 1'b0;
            end
            else
            begin : g_mid_r
                assign right_key = cell_key[i+1];
                assign right_lt  = lt[i+1];
            end

            sse_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occ       (occ[i]),
                .key_bcast (key_reg),
                .left_key  (left_key),
                .right_key (right_key),
                .left_lt   (left_lt),
                .right_lt  (right_lt),
                .key_q     (cell_key[i]),
                .lt_q      (lt[i]),
                .le_q      (le[i])
            );
        end
    endgenerate

    // ---------------- decode ----------------
    assign found       = |(le & ~lt);
    assign succ_exists = |(occ & ~le);
    assign empty       = (cnt_reg == '0);
    assign full        = (cnt_reg == CNT_W'(CAPACITY));
    assign sel_last    = occ & ~occ_up;
    assign sel_pred    = lt & ~lt_up;
    assign sel_succ    = occ & ~le & le_dn;

    always_comb
    begin
        sel_key = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            sel_key = sel_key | (cell_key[j] & {KEY_WIDTH{sel[j]}});
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        use_sel     = 1'b0;
        sel         = '0;
        ins_req     = 1'b0;
        rm_req      = 1'b0;
        rm_mode     = RM_ALL;
        cnt_next    = cnt_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (found)
                begin
                    status_next = ST_DUP;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ins_req  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_REMOVE, OP_EXISTS:
            begin
                if (!found)
                begin
                    status_next = ST_NONE;
                end
                else if (op_reg == OP_REMOVE)
                begin
                    rm_req   = 1'b1;
                    rm_mode  = RM_FROM_LT;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_MIN, OP_POP_MIN:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    use_sel = 1'b1;
                    sel     = CAPACITY'(1);
                    if (op_reg == OP_POP_MIN)
                    begin
                        rm_req   = 1'b1;
                        rm_mode  = RM_ALL;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            OP_MAX, OP_POP_MAX:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    use_sel = 1'b1;
                    sel     = sel_last;
                    if (op_reg == OP_POP_MAX)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            OP_PRED, OP_POP_PRED:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!lt[0])
                begin
                    status_next = ST_NONE;
                end
                else
                begin
                    use_sel = 1'b1;
                    sel     = sel_pred;
                    if (op_reg == OP_POP_PRED)
                    begin
                        rm_req   = 1'b1;
                        rm_mode  = RM_FROM_PRED;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            OP_SUCC, OP_POP_SUCC:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!succ_exists)
                begin
                    status_next = ST_NONE;
                end
                else
                begin
                    use_sel = 1'b1;
                    sel     = sel_succ;
                    if (op_reg == OP_POP_SUCC)
                    begin
                        rm_req   = 1'b1;
                        rm_mode  = RM_FROM_LE;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                cnt_next = '0;
            end
            default: ;
        endcase
    end

    assign ctl.cmp  = cmp_en;
    assign ctl.ins  = commit && ins_req;
    assign ctl.rm   = commit && rm_req;
    assign ctl.mode = rm_mode;

    // ---------------- count and result ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                cnt_reg <= cnt_next;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg  <= status_next;
            value_reg   <= use_sel ? sel_key : '0;
            cnt_out_reg <= cnt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign count     = cnt_out_reg;

endmodule

// File: sv/sse_check.sv
module sse_check (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [sse_pkg::STATUS_W-1:0]       status,
    input logic [sse_pkg::KEY_WIDTH-1:0]      value,
    input logic [sse_pkg::CNT_W-1:0]          count
);
    import sse_pkg::*;

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value)
            && $stable(count))
        else $error("result changed while stalled");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (value == '0))
        else $error("nonzero value with failing status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (count == '0))
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
        else $error("full status below capacity");

endmodule

bind sorted_set_engine_unit sse_check u_sse_check (.*);

// File: bench/sorted_set_engine_unit_tb.sv
import sse_pkg::*;

typedef struct {
    status_t              status;
    logic [KEY_WIDTH-1:0] value;
    logic [CNT_W-1:0]     count;
} set_outcome_t;

class set_scoreboard;
    logic [KEY_WIDTH-1:0] held[$];      // live keys, ascending
    set_outcome_t         outcomes[$];  // expected results, oldest first
    int                   errors;

    // Number of held keys below k, or at or below k when or_equal is set
    function int rank_of(logic [KEY_WIDTH-1:0] k, bit or_equal);
        int i;
        i = 0;
        while (i < held.size() && (held[i] < k || (or_equal && held[i] == k)))
            i++;
        return i;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_WIDTH-1:0] k);
        set_outcome_t o;
        int p;
        int n;
        n = held.size();
        o.status = ST_OK;
        o.value  = '0;
        case (op)
            OP_INSERT: begin
                p = rank_of(k, 1'b0);
                if (p < n && held[p] == k)
                    o.status = ST_DUP;
                else if (n >= CAPACITY)
                    o.status = ST_FULL;
                else
                    held.insert(p, k);
            end
            OP_REMOVE, OP_EXISTS: begin
                p = rank_of(k, 1'b0);
                if (p < n && held[p] == k) begin
                    if (op == OP_REMOVE)
                        held.delete(p);
                end
                else
                    o.status = ST_NONE;
            end
            OP_MIN, OP_MAX, OP_POP_MIN, OP_POP_MAX: begin
                if (n == 0)
                    o.status = ST_EMPTY;
                else if (op == OP_MIN || op == OP_POP_MIN) begin
                    o.value = held[0];
                    if (op == OP_POP_MIN)
                        held.delete(0);
                end
                else begin
                    o.value = held[n-1];
                    if (op == OP_POP_MAX)
                        held.delete(n-1);
                end
            end
            OP_PRED, OP_POP_PRED: begin
                p = rank_of(k, 1'b0);
                if (n == 0)
                    o.status = ST_EMPTY;
                else if (p == 0)
                    o.status = ST_NONE;
                else begin
                    o.value = held[p-1];
                    if (op == OP_POP_PRED)
                        held.delete(p-1);
                end
            end
            OP_SUCC, OP_POP_SUCC: begin
                p = rank_of(k, 1'b1);
                if (n == 0)
                    o.status = ST_EMPTY;
                else if (p >= n)
                    o.status = ST_NONE;
                else begin
                    o.value = held[p];
                    if (op == OP_POP_SUCC)
                        held.delete(p);
                end
            end
            OP_CLEAR:
                held.delete();
            default:
                ;
        endcase
        o.count = CNT_W'(held.size());
        outcomes.push_back(o);
    endfunction

    task report(string what);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", what);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [KEY_WIDTH-1:0] val,
                      logic [CNT_W-1:0] cnt);
        set_outcome_t want;
        if (outcomes.size() == 0) begin
            report($sformatf("unexpected result status=%0d value=%h count=%0d",
                             st, val, cnt));
            return;
        end
        want = outcomes.pop_front();
        if (st !== want.status)
            report($sformatf("status %0d, want %0d", st, want.status));
        if (val !== want.value)
            report($sformatf("value %h, want %h", val, want.value));
        if (cnt !== want.count)
            report($sformatf("count %0d, want %0d", cnt, want.count));
    endtask
endclass

module sorted_set_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0]      OP_SPARE_LO = 4'd12;
    localparam logic [OP_W-1:0]      OP_SPARE_HI = 4'd15;
    localparam logic [KEY_WIDTH-1:0] KEY_STRIDE  = 32'h0291_7C15;
    localparam int                   POOL_LAST   = 95;
    localparam int                   HOLD_CYCLES = 250;
    localparam int                   DRAIN_WAIT  = 8;
    localparam int                   CYCLE_LIMIT = 400_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode    = '0;
    logic [KEY_WIDTH-1:0]  key       = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [KEY_WIDTH-1:0]  value;
    logic [CNT_W-1:0]      count;

    logic                  hold_off       = 1'b0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    cycles         = 0;
    logic [KEY_WIDTH-1:0]  extreme_keys[4] = '{32'h0, 32'h1, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

    set_scoreboard sb = new();

    sorted_set_engine_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value     (value),
        .count     (count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL sorted_set_engine_unit");
            $finish;
        end
    end

    // Result side: check each transaction, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(status, value, count);
            out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic hold_receiver(int n);
        hold_off <= 1'b1;
        repeat (n) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [KEY_WIDTH-1:0] k);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(op, k);
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int r;
        logic [KEY_WIDTH-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 20 && sb.held.size() > 0)
            k = sb.held[$urandom_range(0, sb.held.size() - 1)];
        else if (r < 60)
            k = KEY_STRIDE * $urandom_range(0, POOL_LAST);
        else if (r < 70)
            k = KEY_STRIDE * $urandom_range(0, POOL_LAST)
                + ($urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF);
        else if (r < 80)
            k = extreme_keys[$urandom_range(0, 3)];
        else
            k = $urandom();
        return k;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int insert_pct);
        int r;
        if ($urandom_range(0, 99) < insert_pct)
            return OP_INSERT;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_CLEAR;
        if (r < 6)
            return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        return OP_W'($urandom_range(OP_REMOVE, OP_POP_SUCC));
    endfunction

    // Clear, fill to capacity, then try a duplicate and a key that cannot fit
    task automatic fill_to_capacity();
        send_request(OP_CLEAR, pick_key());
        while (sb.held.size() < CAPACITY)
            send_request(OP_INSERT, pick_key());
        send_request(OP_INSERT, sb.held[$urandom_range(0, CAPACITY - 1)]);
        send_request(OP_INSERT, $urandom());
    endtask

    task automatic mixed_run(int n, int insert_pct);
        repeat (n) send_request(pick_op(insert_pct), pick_key());
    endtask

    initial
    begin
        int ph;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty set, extremes, strict neighbors, spare codes, clear
        send_request(OP_MIN,      32'h0);
        send_request(OP_POP_MAX,  32'h0);
        send_request(OP_REMOVE,   32'h5);
        send_request(OP_EXISTS,   32'h0);
        send_request(OP_PRED,     32'hFFFF_FFFF);
        send_request(OP_SUCC,     32'h0);
        send_request(OP_POP_PRED, 32'hFFFF_FFFF);
        send_request(OP_POP_SUCC, 32'h0);
        send_request(OP_INSERT,   32'h0);
        send_request(OP_INSERT,   32'hFFFF_FFFF);
        send_request(OP_INSERT,   32'h8000_0000);
        send_request(OP_INSERT,   32'h0);
        send_request(OP_EXISTS,   32'hFFFF_FFFF);
        send_request(OP_PRED,     32'h0);
        send_request(OP_SUCC,     32'hFFFF_FFFF);
        send_request(OP_PRED,     32'h8000_0000);
        send_request(OP_SUCC,     32'h8000_0000);
        send_request(OP_MAX,      32'h0);
        send_request(OP_SPARE_LO, 32'hA5A5_5A5A);
        send_request(OP_SPARE_HI, 32'h5A5A_A5A5);
        send_request(OP_POP_PRED, 32'h8000_0001);
        send_request(OP_POP_SUCC, 32'h0);
        send_request(OP_POP_MIN,  32'h0);
        send_request(OP_INSERT,   32'h1234_5678);
        send_request(OP_CLEAR,    32'h0);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 59; end
                default: begin send_idle_pct = 8; recv_stall_pct <= 8; end
            endcase
            fill_to_capacity();
            if (ph == 0)
                fork
                    hold_receiver(HOLD_CYCLES);
                join_none
            mixed_run(80, 55);
            mixed_run(80, 80);
            mixed_run(80, 30);
            mixed_run(40, 10);
        end

        in_valid <= 1'b0;
        recv_stall_pct <= 0;
        while (sb.outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS sorted_set_engine_unit");
        else
            $display("FAIL sorted_set_engine_unit");
        $finish;
    end
endmodule
